// ===== hw/rtl/sequential_list_insert_range_delete_macros.svh =====
// assertion macros for the sequential list block
// used by the top level only; no other dependencies
`ifndef SEQUENTIAL_LIST_INSERT_RANGE_DELETE_MACROS_SVH
`define SEQUENTIAL_LIST_INSERT_RANGE_DELETE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SLRD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SLRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/slrd_pkg.sv =====
// shared types and constants for the sequential list block
// no dependencies
package slrd_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 2;
  localparam int POS_W    = 5;
  localparam int COUNT_W  = 5;
  localparam int CMP_W    = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

  localparam int S_TDATA_W = 104;  // 5 + 3*32 = 101, padded to bytes
  localparam int S_TUSER_W = KIND_W;
  localparam int M_TDATA_W = 40;   // 5 + 32 = 37, padded to bytes
  localparam int M_TUSER_W = 1;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] range_low;
    logic signed [DATA_W-1:0] range_high;
  } cmd_t;

  typedef struct packed {
    logic                     ok;
    logic [COUNT_W-1:0]       count;
    logic signed [DATA_W-1:0] read_value;
  } res_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

endpackage

// ===== hw/rtl/sequential_list_insert_range_delete.sv =====
// channel  | dir | tdata (low bit up)                           | tuser
// s        | in  | position, value, range_low, range_high, pad  | kind
// m        | out | count, read_value, pad                       | ok
// one command at a time; the single read port of the entry memory sets the pace
// a read fetches the addressed entry; an insert moves each entry from the tail down
// to the position one slot up, then writes the value; a range delete scans each slot
// and on a hit trims in-range tail entries and moves the last survivor into the hole
// reset clears the list length and the output valid flag; entries need no clearing
// the result register frees the sequencer, so a new transfer is taken while m stalls
`include "sequential_list_insert_range_delete_macros.svh"

module sequential_list_insert_range_delete (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // position[4:0], value[36:5], range_low[68:37], range_high[100:69], zero pad
  input  logic [slrd_pkg::S_TDATA_W-1:0]   s_tdata,
  // kind[1:0]
  input  logic [slrd_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // count[4:0], read_value[36:5], zero pad
  output logic [slrd_pkg::M_TDATA_W-1:0]   m_tdata,
  // ok[0]
  output logic [slrd_pkg::M_TUSER_W-1:0]   m_tuser
);

  localparam int PW = slrd_pkg::POS_W;
  localparam int DW = slrd_pkg::DATA_W;
  localparam int CNW = slrd_pkg::COUNT_W;

  slrd_pkg::cmd_t     cmd;
  slrd_pkg::res_t     res;
  slrd_pkg::mem_req_t mem_req;
  logic signed [DW-1:0] mem_rdata;
  logic res_valid, res_ready;

  assign cmd.kind       = s_tuser;
  assign cmd.position   = s_tdata[PW-1:0];
  assign cmd.value      = s_tdata[PW+DW-1:PW];
  assign cmd.range_low  = s_tdata[PW+2*DW-1:PW+DW];
  assign cmd.range_high = s_tdata[PW+3*DW-1:PW+2*DW];

  slrd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (s_tvalid),
    .cmd_ready (s_tready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  slrd_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {(slrd_pkg::M_TDATA_W - CNW - DW)'(0), res.read_value, res.count};
      m_tuser <= res.ok;
    end
  end

  `SLRD_ASSERT_SAME(a_count_bound, clk, rst, m_tvalid, m_tdata[CNW-1:0] <= CNW'(slrd_pkg::CAPACITY), "list length above capacity")
  `SLRD_ASSERT_SAME(a_rdv_zero, clk, rst, m_tvalid && !m_tuser[0], m_tdata[CNW+DW-1:CNW] == '0, "read value set on a rejected command")
  `SLRD_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready, "second command taken while one is in work")
  `SLRD_ASSERT_SAME(a_mem_port, clk, rst, mem_req.we && mem_req.re, mem_req.waddr != mem_req.raddr, "read and write of the same entry in one cycle")

endmodule

// ===== hw/rtl/slrd_mem.sv =====
// entry storage: one write port, one read port, registered read data
// depends on slrd_pkg
module slrd_mem (
  input  logic                         clk,
  input  slrd_pkg::mem_req_t           req,
  output logic [slrd_pkg::DATA_W-1:0]  rdata
);

  logic [slrd_pkg::DATA_W-1:0] mem [slrd_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== hw/rtl/slrd_ctrl.sv =====
// command sequencer: insert shift, range delete scan and read over the entry memory
// depends on slrd_pkg; drives slrd_mem through a mem_req_t
module slrd_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  output logic                               cmd_ready,
  input  slrd_pkg::cmd_t                     cmd,
  output logic                               res_valid,
  input  logic                               res_ready,
  output slrd_pkg::res_t                     res,
  output slrd_pkg::mem_req_t                 mem_req,
  input  logic signed [slrd_pkg::DATA_W-1:0] mem_rdata
);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_EXEC      = 4'd1;
  localparam logic [3:0] ST_INS_SHIFT = 4'd2;
  localparam logic [3:0] ST_INS_PUT   = 4'd3;
  localparam logic [3:0] ST_DEL_RDI   = 4'd4;
  localparam logic [3:0] ST_DEL_CHKI  = 4'd5;
  localparam logic [3:0] ST_DEL_RDT   = 4'd6;
  localparam logic [3:0] ST_DEL_CHKT  = 4'd7;
  localparam logic [3:0] ST_RD_DATA   = 4'd8;
  localparam logic [3:0] ST_DONE      = 4'd9;

  localparam int AW = slrd_pkg::ADDR_W;
  localparam int LW = slrd_pkg::LEN_W;
  localparam int CW = slrd_pkg::CMP_W;

  logic [3:0]    state, state_next;
  logic [LW-1:0] len, len_next;
  logic [LW-1:0] idx, idx_next;
  logic          wr_pend, wr_pend_next;
  logic [AW-1:0] wr_addr, wr_addr_next;
  logic          ok, ok_next;
  logic signed [slrd_pkg::DATA_W-1:0] rdv, rdv_next;
  slrd_pkg::cmd_t cmd_r;

  logic          hit;
  logic [CW-1:0] pos_x, len_x, idx_x;

  assign hit   = (mem_rdata >= cmd_r.range_low) && (mem_rdata <= cmd_r.range_high);
  assign pos_x = CW'(cmd_r.position);
  assign len_x = CW'(len);
  assign idx_x = CW'(idx);

  assign cmd_ready      = (state == ST_IDLE);
  assign res_valid      = (state == ST_DONE);
  assign res.ok         = ok;
  assign res.count      = slrd_pkg::COUNT_W'(len);
  assign res.read_value = rdv;

  always_comb begin
    state_next    = state;
    len_next      = len;
    idx_next      = idx;
    ok_next       = ok;
    rdv_next      = rdv;
    wr_pend_next  = 1'b0;
    wr_addr_next  = wr_addr;
    // shift writes land in the cycle after their read
    mem_req.re    = 1'b0;
    mem_req.raddr = '0;
    mem_req.we    = wr_pend;
    mem_req.waddr = wr_addr;
    mem_req.wdata = mem_rdata;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ok_next    = 1'b0;
        rdv_next   = '0;
        state_next = ST_DONE;
        case (cmd_r.kind)
          slrd_pkg::KIND_INSERT: begin
            if ((pos_x != '0) && (pos_x <= len_x + CW'(1)) &&
                (len_x < CW'(slrd_pkg::CAPACITY))) begin
              idx_next   = len;
              state_next = ST_INS_SHIFT;
            end
          end
          slrd_pkg::KIND_DELETE: begin
            if ((cmd_r.range_low < cmd_r.range_high) && (len != '0)) begin
              ok_next    = 1'b1;
              idx_next   = '0;
              state_next = ST_DEL_RDI;
            end
          end
          slrd_pkg::KIND_READ: begin
            if ((pos_x != '0) && (pos_x <= len_x)) begin
              mem_req.re    = 1'b1;
              mem_req.raddr = AW'(cmd_r.position - slrd_pkg::POS_W'(1));
              state_next    = ST_RD_DATA;
            end
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end
      ST_INS_SHIFT: begin
        // read slot idx-1 now, write it to slot idx next cycle
        if (idx_x >= pos_x) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = AW'(idx - LW'(1));
          wr_pend_next  = 1'b1;
          wr_addr_next  = AW'(idx);
          idx_next      = idx - LW'(1);
        end else begin
          state_next = ST_INS_PUT;
        end
      end
      ST_INS_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = AW'(cmd_r.position - slrd_pkg::POS_W'(1));
        mem_req.wdata = cmd_r.value;
        len_next      = len + LW'(1);
        ok_next       = 1'b1;
        state_next    = ST_DONE;
      end
      ST_DEL_RDI: begin
        if (idx < len) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = AW'(idx);
          state_next    = ST_DEL_CHKI;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DEL_CHKI: begin
        if (hit) begin
          state_next = ST_DEL_RDT;
        end else begin
          idx_next   = idx + LW'(1);
          state_next = ST_DEL_RDI;
        end
      end
      ST_DEL_RDT: begin
        if (len > idx) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = AW'(len - LW'(1));
          state_next    = ST_DEL_CHKT;
        end else begin
          idx_next   = idx + LW'(1);
          state_next = ST_DEL_RDI;
        end
      end
      ST_DEL_CHKT: begin
        len_next = len - LW'(1);
        if (hit) begin
          // tail entry also in range: trim and look at the new tail
          state_next = ST_DEL_RDT;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = AW'(idx);
          mem_req.wdata = mem_rdata;
          idx_next      = idx + LW'(1);
          state_next    = ST_DEL_RDI;
        end
      end
      ST_RD_DATA: begin
        rdv_next   = mem_rdata;
        ok_next    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      len     <= '0;
      wr_pend <= 1'b0;
    end else begin
      state   <= state_next;
      len     <= len_next;
      wr_pend <= wr_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    wr_addr <= wr_addr_next;
    ok      <= ok_next;
    rdv     <= rdv_next;
    if (cmd_valid && cmd_ready) begin
      cmd_r <= cmd;
    end
  end

endmodule

// ===== tb/sv/slrd_list_checker.sv =====
`timescale 1ns / 100ps
// result checker for the sequential list block: keeps a shadow copy of the list,
// predicts the result of each accepted command and compares the result transfers
// depends on slrd_pkg for widths, command codes and the command/result structs
module slrd_list_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [slrd_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic [slrd_pkg::S_TUSER_W-1:0]  s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [slrd_pkg::M_TDATA_W-1:0]  m_tdata,
  input  logic [slrd_pkg::M_TUSER_W-1:0]  m_tuser,
  output int                              mismatch_count,
  output int                              outstanding,
  output logic [slrd_pkg::COUNT_W-1:0]    shadow_len
);
  import slrd_pkg::*;

  logic signed [DATA_W-1:0] shadow_mem [CAPACITY];
  int                       used;
  res_t                     outcome_q [$];
  int                       result_index;

  assign shadow_len = COUNT_W'(used);

  function automatic bit in_window(logic signed [DATA_W-1:0] v,
                                   logic signed [DATA_W-1:0] lo,
                                   logic signed [DATA_W-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  // updates the shadow list and returns the result the command must give
  function automatic res_t apply_list_cmd(cmd_t c);
    res_t r;
    int   i;
    r = '0;
    case (c.kind)
      KIND_INSERT: begin
        if (c.position >= 1 && c.position <= used + 1 && used < CAPACITY) begin
          for (int j = used; j >= c.position; j--)
            shadow_mem[j] = shadow_mem[j-1];
          shadow_mem[c.position-1] = c.value;
          used++;
          r.ok = 1'b1;
        end
      end
      KIND_DELETE: begin
        if (c.range_low < c.range_high && used > 0) begin
          i = 0;
          while (i < used) begin
            if (in_window(shadow_mem[i], c.range_low, c.range_high)) begin
              // drop hits off the tail, then pull the last survivor into the hole
              while (used > i && in_window(shadow_mem[used-1], c.range_low, c.range_high))
                used--;
              if (used > i) begin
                shadow_mem[i] = shadow_mem[used-1];
                used--;
              end
            end
            i++;
          end
          r.ok = 1'b1;
        end
      end
      KIND_READ: begin
        if (c.position >= 1 && c.position <= used) begin
          r.ok         = 1'b1;
          r.read_value = shadow_mem[c.position-1];
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(used);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    cmd_t cmd;
    res_t got;
    res_t want;
    if (rst) begin
      used           = 0;
      mismatch_count = 0;
      outstanding    = 0;
      result_index   = 0;
      outcome_q.delete();
    end else begin
      // the result side first: a result never belongs to a command taken this edge
      if (m_tvalid && m_tready) begin
        got.ok         = m_tuser[0];
        got.count      = m_tdata[COUNT_W-1:0];
        got.read_value = m_tdata[COUNT_W+DATA_W-1:COUNT_W];
        if (outcome_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: result %0d with no command waiting: ok=%0d count=%0d read_value=%0d",
                     $time, result_index, got.ok, got.count, got.read_value);
          mismatch_count++;
        end else begin
          want = outcome_q.pop_front();
          if (got.ok !== want.ok || got.count !== want.count ||
              got.read_value !== want.read_value) begin
            if (mismatch_count < 10)
              $display("%0t: result %0d expected ok=%0d count=%0d read_value=%0d, got ok=%0d count=%0d read_value=%0d",
                       $time, result_index, want.ok, want.count, want.read_value,
                       got.ok, got.count, got.read_value);
            mismatch_count++;
          end
        end
        result_index++;
      end
      if (s_tvalid && s_tready) begin
        cmd.kind       = s_tuser[KIND_W-1:0];
        cmd.position   = s_tdata[POS_W-1:0];
        cmd.value      = s_tdata[POS_W+DATA_W-1:POS_W];
        cmd.range_low  = s_tdata[POS_W+2*DATA_W-1:POS_W+DATA_W];
        cmd.range_high = s_tdata[POS_W+3*DATA_W-1:POS_W+2*DATA_W];
        outcome_q.push_back(apply_list_cmd(cmd));
      end
      outstanding = outcome_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_sequential_list_insert_range_delete.sv =====
`timescale 1ns / 100ps
// top of the sequential list testbench: clock, reset, command stimulus and verdict
// depends on slrd_pkg, the block and slrd_list_checker
module tb_sequential_list_insert_range_delete;
  import slrd_pkg::*;

  localparam logic [KIND_W-1:0]     KIND_UNUSED  = 2'd3;
  localparam logic signed [DATA_W-1:0] INT_MIN   = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] INT_MAX   = 32'sh7fff_ffff;
  localparam int                    PHASE_ITEMS  = 350;
  localparam int                    QUIET_LIMIT  = 3000;
  localparam int                    DRAIN_CYCLES = 100;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata  = '0;
  logic [S_TUSER_W-1:0]  s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [M_TUSER_W-1:0]  m_tuser;

  int                    mismatch_count;
  int                    outstanding;
  logic [COUNT_W-1:0]    shadow_len;
  int                    gap_pct   = 0;
  int                    stall_pct = 0;
  int                    quiet_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sequential_list_insert_range_delete u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  slrd_list_checker u_list_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding),
    .shadow_len     (shadow_len)
  );

  always @(negedge clk)
    m_tready <= ($urandom_range(99) >= stall_pct);

  // ends the run when no transfer happens on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_list_cmd(input logic [KIND_W-1:0]        kind,
                               input logic [POS_W-1:0]         pos,
                               input logic signed [DATA_W-1:0] val,
                               input logic signed [DATA_W-1:0] lo,
                               input logic signed [DATA_W-1:0] hi);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = kind;
    s_tdata  = {{(S_TDATA_W-POS_W-3*DATA_W){1'b0}}, hi, lo, val, pos};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // mostly small values so that inserted entries collide with delete ranges
  function automatic logic signed [DATA_W-1:0] pick_value();
    int roll;
    int t;
    roll = $urandom_range(99);
    t    = $urandom_range(40);
    if (roll < 78) return t - 20;
    if (roll < 82) return INT_MIN;
    if (roll < 86) return INT_MAX;
    if (roll < 88) return -1;
    return $urandom;
  endfunction

  task automatic random_list_cmd(input bit grow);
    int                       roll;
    int                       len;
    int                       ins_pct;
    int                       del_pct;
    int                       base;
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
    len     = int'(shadow_len);
    ins_pct = grow ? 62 : 25;
    del_pct = grow ? 6 : 25;
    roll    = $urandom_range(99);
    if (roll < ins_pct)
      kind = KIND_INSERT;
    else if (roll < ins_pct + del_pct)
      kind = KIND_DELETE;
    else if (roll < 95)
      kind = KIND_READ;
    else
      kind = KIND_UNUSED;

    if ($urandom_range(99) < 12)
      pos = POS_W'($urandom_range(31));
    else if (kind == KIND_INSERT)
      pos = POS_W'($urandom_range(len + 1, 1));
    else
      pos = (len == 0) ? POS_W'(1) : POS_W'($urandom_range(len, 1));

    roll = $urandom_range(99);
    base = $urandom_range(44);
    if (roll < 70) begin
      lo = base - 24;
      hi = lo + $urandom_range(12, 1);
    end else if (roll < 80) begin
      lo = $urandom;
      hi = $urandom;
    end else if (roll < 88) begin
      // equal or inverted bounds
      lo = base - 24;
      hi = lo - $urandom_range(3);
    end else if (roll < 94) begin
      lo = INT_MIN;
      hi = INT_MAX;
    end else begin
      lo = INT_MIN;
      hi = pick_value();
    end
    send_list_cmd(kind, pos, pick_value(), lo, hi);
  endtask

  initial begin
    int phase;
    int n;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty list and bad positions
    send_list_cmd(KIND_READ,   5'd1, 0, 0, 0);
    send_list_cmd(KIND_DELETE, 5'd0, 0, -5, 5);
    send_list_cmd(KIND_INSERT, 5'd0, 7, 0, 0);
    send_list_cmd(KIND_INSERT, 5'd2, 7, 0, 0);
    // front, tail and middle inserts with extreme values
    send_list_cmd(KIND_INSERT, 5'd1, INT_MAX, 0, 0);
    send_list_cmd(KIND_INSERT, 5'd1, INT_MIN, 0, 0);
    send_list_cmd(KIND_INSERT, 5'd3, 0, 0, 0);
    send_list_cmd(KIND_INSERT, 5'd2, -1, 0, 0);
    send_list_cmd(KIND_READ,   5'd1, 0, 0, 0);
    send_list_cmd(KIND_READ,   5'd4, 0, 0, 0);
    send_list_cmd(KIND_READ,   5'd5, 0, 0, 0);
    send_list_cmd(KIND_READ,   5'd31, INT_MIN, INT_MAX, INT_MIN);
    send_list_cmd(KIND_UNUSED, 5'd1, 3, -3, 3);
    send_list_cmd(KIND_DELETE, 5'd0, 0, 0, 0);
    send_list_cmd(KIND_DELETE, 5'd0, 0, 3, -3);
    // fill to capacity, ending in two in-range entries at the tail
    for (n = 0; n < 12; n++)
      send_list_cmd(KIND_INSERT, 5'(n + 5), (n == 10) ? 0 : (n == 11) ? -1 : 100 + n, 0, 0);
    send_list_cmd(KIND_INSERT, 5'd1, 55, 0, 0);
    send_list_cmd(KIND_DELETE, 5'd0, 0, -3, -2);
    send_list_cmd(KIND_DELETE, 5'd0, 0, -1, 0);
    send_list_cmd(KIND_DELETE, 5'd0, 0, INT_MIN, INT_MAX);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 52; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 52; end
        default: begin gap_pct = 7; stall_pct = 7; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++)
        random_list_cmd(((n / 40) % 2) == 0);
    end

    @(negedge clk);
    s_tvalid  = 1'b0;
    stall_pct = 0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sequential_list_insert_range_delete.f =====
+incdir+hw/rtl
hw/rtl/slrd_pkg.sv
hw/rtl/slrd_mem.sv
hw/rtl/slrd_ctrl.sv
hw/rtl/sequential_list_insert_range_delete.sv
tb/sv/slrd_list_checker.sv
tb/sv/tb_sequential_list_insert_range_delete.sv
